// ===== hw/rtl/ddps_pkg.sv =====
// ----------------------------------------------------------------------------
// ddps_pkg
// Shared constants, codes and types of the differential drive PID step.
// ----------------------------------------------------------------------------
`default_nettype none

package ddps_pkg;

  localparam int ENCODER_BITS_DEF = 20;

  localparam int MODE_W   = 2;
  localparam int TARGET_W = 20;
  localparam int VEL_W    = 10;
  localparam int TIME_W   = 16;
  localparam int GYRO_W   = 16;
  localparam int POT_W    = 12;
  localparam int DRIVE_W  = 14;
  localparam int CAT_W    = 8;
  localparam int STATUS_W = 2;
  localparam int INTEG_W  = 16;
  localparam int FRAC_W   = 24;

  // Q0.24 gains
  localparam logic [22:0] GAIN_KP      = 23'd5033165;
  localparam logic [10:0] GAIN_KI      = 11'd1678;
  localparam logic [22:0] GAIN_KD      = 23'd2852127;
  localparam logic [22:0] GAIN_KP_TURN = 23'd2768241;
  localparam logic [22:0] GAIN_KD_TURN = 23'd1677722;
  localparam logic [21:0] GAIN_DRIFT   = 22'd2516582;

  // product widths
  localparam int P_W = 43;
  localparam int I_W = 27;
  localparam int D_W = 45;

  localparam int                  INT_ZONE      = 137;
  localparam logic [INTEG_W-1:0]  INT_LIMIT     = 16'd50000;
  localparam int                  STOP_ERROR    = 25;
  localparam logic [POT_W-1:0]    POT_THRESHOLD = 12'd960;
  localparam logic [CAT_W-1:0]    RELOAD_SPEED  = 8'd200;
  localparam int                  DRIVE_LIMIT   = 8191;
  localparam logic [VEL_W-1:0]    VEL_RESET     = 10'd200;

  localparam logic [MODE_W-1:0] MODE_FWD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_RUN     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REACHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_TARGET  = 2'd1;
  localparam logic [1:0] REG_MAX_VEL = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [TARGET_W-1:0] target_count;
    logic [VEL_W-1:0]    max_velocity;
    logic [TIME_W-1:0]   timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                 run;
    logic                 reload;
    logic [STATUS_W-1:0]  status;
    logic [P_W-1:0]       p_prod;
    logic [I_W-1:0]       i_prod;
    logic signed [D_W-1:0] d_prod;
  } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/differential_drive_pid_step.sv =====
// ----------------------------------------------------------------------------
// differential_drive_pid_step
// PID move controller for a differential drive with integral zone, drift
// correction and catapult reload.
//
// Item channel (item_valid/item_ready): one beat per 50 Hz tick with op,
// encoder sums, gyro heading, catapult pot and elapsed time; op = 0 starts
// a move and clears the integrator, previous error and finish code.
// Result channel (result_valid/result_ready): one beat per item with the
// left/right drive, catapult drive and status.
// Throughput is one beat per cycle unless result_ready stalls. Stages: input
// register, product register (gain multipliers) and result register.
// Each stage holds its beat while the next one is full, so the block keeps
// taking beats while a result waits until all three stages are occupied.
// Reset empties the pipeline and returns the controller and registers to
// their defaults (max_velocity 200). Configure over APB only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_pid_step #(
  parameter int ENCODER_BITS = ddps_pkg::ENCODER_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [3:0]                           paddr,
  input  wire [31:0]                          pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire                                 item_valid,
  output logic                                item_ready,
  input  wire                                 op,
  input  wire [ENCODER_BITS-1:0]              left_sum,
  input  wire [ENCODER_BITS-1:0]              right_sum,
  input  wire signed [ddps_pkg::GYRO_W-1:0]   gyro_reading,
  input  wire [ddps_pkg::POT_W-1:0]           catapult_pot,
  input  wire [ddps_pkg::TIME_W-1:0]          elapsed_ms,
  output logic                                result_valid,
  input  wire                                 result_ready,
  output logic signed [ddps_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [ddps_pkg::DRIVE_W-1:0] right_drive,
  output logic [ddps_pkg::CAT_W-1:0]          catapult_drive,
  output logic [ddps_pkg::STATUS_W-1:0]       status
);
  import ddps_pkg::*;

  localparam int DRIFT_W = ((ENCODER_BITS + 1) > 16) ? (ENCODER_BITS + 1) : 16;
  localparam int PD_W    = DRIFT_W + 23;

  cfg_t                   cfg;
  logic                   cfg_wr;
  logic                   take;
  logic                   stage_valid;
  stage_t                 stage;
  logic signed [PD_W-1:0] drift_prod;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_FWD;
      cfg.target_count <= '0;
      cfg.max_velocity <= VEL_RESET;
      cfg.timeout_ms   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:    cfg.mode         <= pwdata[MODE_W-1:0];
        REG_TARGET:  cfg.target_count <= pwdata[TARGET_W-1:0];
        REG_MAX_VEL: cfg.max_velocity <= pwdata[VEL_W-1:0];
        REG_TIMEOUT: cfg.timeout_ms   <= pwdata[TIME_W-1:0];
        default:     cfg.mode         <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:    prdata = 32'(cfg.mode);
      REG_TARGET:  prdata = 32'(cfg.target_count);
      REG_MAX_VEL: prdata = 32'(cfg.max_velocity);
      REG_TIMEOUT: prdata = 32'(cfg.timeout_ms);
      default:     prdata = '0;
    endcase
  end

  ddps_track #(
    .ENCODER_BITS(ENCODER_BITS)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .op          (op),
    .left_sum    (left_sum),
    .right_sum   (right_sum),
    .gyro_reading(gyro_reading),
    .catapult_pot(catapult_pot),
    .elapsed_ms  (elapsed_ms),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage),
    .drift_prod  (drift_prod)
  );

  ddps_drive #(
    .ENCODER_BITS(ENCODER_BITS)
  ) u_drive (
    .clk           (clk),
    .rst           (rst),
    .mode          (cfg.mode),
    .max_velocity  (cfg.max_velocity),
    .stage_valid   (stage_valid),
    .stage         (stage),
    .drift_prod    (drift_prod),
    .take          (take),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .catapult_drive(catapult_drive),
    .status        (status)
  );

`ifndef SYNTH
  // a finished move drives nothing
  a_idle_drives: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_RUN) |->
      (left_drive == 0) && (right_drive == 0) && (catapult_drive == 0))
    else $error("drive active with move finished");

  a_cat_levels: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (catapult_drive == 0) || (catapult_drive == RELOAD_SPEED))
    else $error("catapult drive off its two levels");

  a_drive_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (left_drive != 14'sh2000) && (right_drive != 14'sh2000))
    else $error("drive outside saturation range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat right after reset");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ddps_track.sv =====
// ----------------------------------------------------------------------------
// ddps_track
// Input register, error and stop decision, integrator state and the
// gain products, registered for the drive stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ddps_track #(
  parameter int ENCODER_BITS = ddps_pkg::ENCODER_BITS_DEF,
  localparam int DRIFT_W = ((ENCODER_BITS + 1) > 16) ? (ENCODER_BITS + 1) : 16,
  localparam int PD_W    = DRIFT_W + 23
) (
  input  wire                              clk,
  input  wire                              rst,
  input  ddps_pkg::cfg_t                   cfg,
  input  wire                              item_valid,
  output logic                             item_ready,
  input  wire                              op,
  input  wire [ENCODER_BITS-1:0]           left_sum,
  input  wire [ENCODER_BITS-1:0]           right_sum,
  input  wire signed [ddps_pkg::GYRO_W-1:0] gyro_reading,
  input  wire [ddps_pkg::POT_W-1:0]        catapult_pot,
  input  wire [ddps_pkg::TIME_W-1:0]       elapsed_ms,
  input  wire                              take,
  output logic                             stage_valid,
  output ddps_pkg::stage_t                 stage,
  output logic signed [PD_W-1:0]           drift_prod
);
  import ddps_pkg::*;

  localparam int ERR_W = ((ENCODER_BITS > TARGET_W) ? ENCODER_BITS : TARGET_W) + 2;

  // input register
  logic                     r_valid;
  logic                     r_op;
  logic [ENCODER_BITS-1:0]  r_lsum;
  logic [ENCODER_BITS-1:0]  r_rsum;
  logic signed [GYRO_W-1:0] r_gyro;
  logic [POT_W-1:0]         r_pot;
  logic [TIME_W-1:0]        r_elapsed;

  // controller state
  logic [INTEG_W-1:0]  integ;
  logic [TARGET_W-1:0] prev;
  logic [STATUS_W-1:0] fin;

  logic s_adv, fire;

  logic                     turning;
  logic signed [GYRO_W:0]   gx;
  logic [GYRO_W:0]          gyro_abs;
  logic [ENCODER_BITS-1:0]  half_sum;
  logic signed [ERR_W-1:0]  err_straight, err_turn, err;
  logic                     stop, timeout, in_zone;
  logic [TARGET_W-1:0]      e_pos;
  logic [INTEG_W:0]         integ_sum;
  logic [INTEG_W-1:0]       integ_next;
  logic signed [TARGET_W:0] diff;
  logic [22:0]              kp, kd;
  logic signed [DRIFT_W-1:0] drift;
  ddps_pkg::stage_t         stage_next;
  logic signed [PD_W-1:0]   pd_next;

  assign s_adv      = !stage_valid || take;
  assign item_ready = !r_valid || s_adv;
  assign fire       = r_valid && s_adv;

  always_comb begin
    turning  = cfg.mode[1];
    gx       = (GYRO_W+1)'(r_gyro);
    gyro_abs = r_gyro[GYRO_W-1] ? (GYRO_W+1)'(-gx) : (GYRO_W+1)'(gx);
    half_sum = (r_lsum >> 1) + (r_rsum >> 1);

    err_straight = $signed(ERR_W'(cfg.target_count)) - $signed(ERR_W'(half_sum));
    err_turn     = $signed(ERR_W'(cfg.target_count)) - $signed(ERR_W'(gyro_abs));
    err          = turning ? err_turn : err_straight;

    stop    = err < $signed(ERR_W'(STOP_ERROR));
    timeout = r_elapsed >= cfg.timeout_ms;
    // on the running path err lies in [25, target_count]
    e_pos   = err[TARGET_W-1:0];
    in_zone = err < $signed(ERR_W'(INT_ZONE));

    integ_sum = (INTEG_W+1)'(integ) + (INTEG_W+1)'(e_pos[7:0]);
    if (!in_zone) begin
      integ_next = '0;
    end else if (integ_sum > (INTEG_W+1)'(INT_LIMIT)) begin
      integ_next = INT_LIMIT;
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end

    diff = $signed({1'b0, e_pos}) - $signed({1'b0, prev});
    kp   = turning ? GAIN_KP_TURN : GAIN_KP;
    kd   = turning ? GAIN_KD_TURN : GAIN_KD;

    if (turning) begin
      drift = $signed(DRIFT_W'(r_lsum)) - $signed(DRIFT_W'(r_rsum));
    end else begin
      drift = DRIFT_W'(r_gyro);
    end

    stage_next.p_prod = kp * e_pos;
    stage_next.i_prod = GAIN_KI * integ_next;
    stage_next.d_prod = $signed({1'b0, kd}) * diff;
    pd_next           = $signed({1'b0, GAIN_DRIFT}) * drift;

    stage_next.reload = r_pot > POT_THRESHOLD;
    stage_next.run    = 1'b0;
    priority if (r_op == OP_START) begin
      stage_next.status = ST_RUN;
    end else if (fin != ST_RUN) begin
      stage_next.status = fin;
    end else if (stop) begin
      stage_next.status = ST_REACHED;
    end else if (timeout) begin
      stage_next.status = ST_TIMEOUT;
    end else begin
      stage_next.status = ST_RUN;
      stage_next.run    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (item_ready) begin
      r_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      r_op      <= op;
      r_lsum    <= left_sum;
      r_rsum    <= right_sum;
      r_gyro    <= gyro_reading;
      r_pot     <= catapult_pot;
      r_elapsed <= elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_adv) begin
      stage_valid <= r_valid;
    end
    if (fire) begin
      stage      <= stage_next;
      drift_prod <= pd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev  <= '0;
      fin   <= ST_RUN;
    end else if (fire) begin
      priority if (r_op == OP_START) begin
        integ <= '0;
        prev  <= '0;
        fin   <= ST_RUN;
      end else if (fin != ST_RUN) begin
        fin <= fin;
      end else if (stop) begin
        fin <= ST_REACHED;
      end else if (timeout) begin
        fin <= ST_TIMEOUT;
      end else begin
        integ <= integ_next;
        prev  <= e_pos;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ddps_drive.sv =====
// ----------------------------------------------------------------------------
// ddps_drive
// Sums the PID products, clamps to max velocity, mixes in drift and
// registers the left, right and catapult commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ddps_drive #(
  parameter int ENCODER_BITS = ddps_pkg::ENCODER_BITS_DEF,
  localparam int DRIFT_W = ((ENCODER_BITS + 1) > 16) ? (ENCODER_BITS + 1) : 16,
  localparam int PD_W    = DRIFT_W + 23
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire [ddps_pkg::MODE_W-1:0]         mode,
  input  wire [ddps_pkg::VEL_W-1:0]          max_velocity,
  input  wire                                stage_valid,
  input  ddps_pkg::stage_t                   stage,
  input  wire signed [PD_W-1:0]              drift_prod,
  output logic                               take,
  output logic                               result_valid,
  input  wire                                result_ready,
  output logic signed [ddps_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [ddps_pkg::DRIVE_W-1:0] right_drive,
  output logic [ddps_pkg::CAT_W-1:0]         catapult_drive,
  output logic [ddps_pkg::STATUS_W-1:0]      status
);
  import ddps_pkg::*;

  localparam int SUM_W = D_W + 1;
  localparam int FV_W  = SUM_W - FRAC_W;
  localparam int LW    = ((PD_W > (VEL_W + 1 + FRAC_W)) ? PD_W : (VEL_W + 1 + FRAC_W)) + 1;
  localparam int TW    = LW - FRAC_W;
  localparam logic signed [TW-1:0] DMAX = TW'(DRIVE_LIMIT);

  // truncate Q24 toward zero, then saturate to the drive range
  function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [LW-1:0] q);
    logic signed [TW-1:0] t;
    t = q[LW-1:FRAC_W];
    if (q[LW-1] && (|q[FRAC_W-1:0])) begin
      t = t + TW'(1);
    end
    if (t > DMAX) begin
      t = DMAX;
    end else if (t < -DMAX) begin
      t = -DMAX;
    end
    return DRIVE_W'(t);
  endfunction

  logic signed [SUM_W-1:0] sum;
  logic signed [FV_W-1:0]  fv_full, vmax;
  logic signed [VEL_W:0]   fv;
  logic signed [LW-1:0]    fl, pd_x, l_q, r_q;
  logic                    l_neg, r_neg;

  assign take = !result_valid || result_ready;

  always_comb begin
    sum = $signed(SUM_W'(stage.p_prod)) + $signed(SUM_W'(stage.i_prod))
        + SUM_W'(stage.d_prod);
    fv_full = sum[SUM_W-1:FRAC_W];
    if (sum[SUM_W-1] && (|sum[FRAC_W-1:0])) begin
      fv_full = fv_full + FV_W'(1);
    end
    vmax = $signed(FV_W'(max_velocity));
    if (fv_full > vmax) begin
      fv = (VEL_W+1)'(vmax);
    end else if (fv_full < -vmax) begin
      fv = (VEL_W+1)'(-vmax);
    end else begin
      fv = (VEL_W+1)'(fv_full);
    end

    fl    = LW'(fv) <<< FRAC_W;
    pd_x  = LW'(drift_prod);
    l_neg = (mode == MODE_BACK) || (mode == MODE_LEFT);
    r_neg = (mode == MODE_BACK) || (mode == MODE_RIGHT);
    l_q   = (l_neg ? -fl : fl) - pd_x;
    r_q   = (r_neg ? -fl : fl) + pd_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= stage_valid;
    end
    if (take && stage_valid) begin
      status <= stage.status;
      if (stage.run) begin
        left_drive     <= to_drive(l_q);
        right_drive    <= to_drive(r_q);
        catapult_drive <= stage.reload ? RELOAD_SPEED : '0;
      end else begin
        left_drive     <= '0;
        right_drive    <= '0;
        catapult_drive <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the differential drive PID step. Move sequences
// (start, encoder or gyro ramp toward the target, ticks after the finish) and
// random noise beats are queued for a valid/ready driver. A bit-accurate
// controller model predicts every drive command when its beat is accepted,
// and the monitor compares each result beat with the oldest prediction.
// Register settings are changed over APB between phases while the block is
// idle. Both channels stall in random bursts only while idle_pct is nonzero.
// ----------------------------------------------------------------------------
module testbench;
  import ddps_pkg::*;

  localparam int EB          = ENCODER_BITS_DEF;
  localparam int QUIET_LIMIT = 2000;

  // controller arithmetic, Q0.24 gains
  localparam longint Q24         = 64'sd16777216;
  localparam longint KP_STRAIGHT = 5033165;
  localparam longint KD_STRAIGHT = 2852127;
  localparam longint KP_TURN     = 2768241;
  localparam longint KD_TURN     = 1677722;
  localparam longint KI_ALL      = 1678;
  localparam longint DRIFT_GAIN  = 2516582;
  localparam longint ZONE        = 137;
  localparam longint INTEG_CAP   = 50000;
  localparam longint STOP_ERR    = 25;
  localparam longint DRIVE_CAP   = 8191;

  typedef struct packed {
    logic                op;
    logic [EB-1:0]       lsum;
    logic [EB-1:0]       rsum;
    logic [GYRO_W-1:0]   gyro;
    logic [POT_W-1:0]    pot;
    logic [TIME_W-1:0]   elapsed;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic [CAT_W-1:0]          catapult;
    logic [STATUS_W-1:0]       status;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic  item_valid = 1'b0;
  logic  item_ready;
  tick_t on_bus     = '0;

  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic [CAT_W-1:0]          catapult_drive;
  logic [STATUS_W-1:0]       status;

  // register shadow, reset values
  logic [MODE_W-1:0]   cfg_mode    = MODE_FWD;
  logic [TARGET_W-1:0] cfg_target  = '0;
  logic [VEL_W-1:0]    cfg_vmax    = 10'd200;
  logic [TIME_W-1:0]   cfg_timeout = '0;

  // controller state
  longint              integ_sum  = 0;
  longint              last_err   = 0;
  logic [STATUS_W-1:0] move_state = ST_RUN;

  tick_t      tick_queue[$];
  drive_cmd_t cmds_due[$];

  int idle_pct     = 0;
  int gap_cnt      = 0;
  int stall_cnt    = 0;
  int items_made   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  differential_drive_pid_step u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .op             (on_bus.op),
    .left_sum       (on_bus.lsum),
    .right_sum      (on_bus.rsum),
    .gyro_reading   (on_bus.gyro),
    .catapult_pot   (on_bus.pot),
    .elapsed_ms     (on_bus.elapsed),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .left_drive     (left_drive),
    .right_drive    (right_drive),
    .catapult_drive (catapult_drive),
    .status         (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One controller step; updates the integrator, last error and finish code.
  function automatic drive_cmd_t compute_drive_cmd(tick_t t);
    drive_cmd_t c;
    longint err, drift, kp, kd, pid, vel, pd, fl, l, r, gyro_v;
    c.left     = '0;
    c.right    = '0;
    c.catapult = '0;
    c.status   = ST_RUN;
    gyro_v     = longint'($signed(t.gyro));
    if (t.op == OP_START) begin
      integ_sum  = 0;
      last_err   = 0;
      move_state = ST_RUN;
      return c;
    end
    if (move_state != ST_RUN) begin
      c.status = move_state;
      return c;
    end
    if (cfg_mode == MODE_LEFT || cfg_mode == MODE_RIGHT) begin
      err   = longint'(cfg_target) - (gyro_v < 0 ? -gyro_v : gyro_v);
      drift = longint'(t.lsum) - longint'(t.rsum);
      kp    = KP_TURN;
      kd    = KD_TURN;
    end else begin
      err   = longint'(cfg_target) - (longint'(t.lsum >> 1) + longint'(t.rsum >> 1));
      drift = gyro_v;
      kp    = KP_STRAIGHT;
      kd    = KD_STRAIGHT;
    end
    if (err < STOP_ERR) begin
      move_state = ST_REACHED;
      c.status   = move_state;
      return c;
    end
    if (t.elapsed >= cfg_timeout) begin
      move_state = ST_TIMEOUT;
      c.status   = move_state;
      return c;
    end
    c.catapult = (t.pot > 12'd960) ? 8'd200 : 8'd0;
    if (err != 0 && err < ZONE && err > -ZONE) integ_sum = integ_sum + err;
    else integ_sum = 0;
    integ_sum = bound(integ_sum, -INTEG_CAP, INTEG_CAP);
    pid = kp * err + KI_ALL * integ_sum;
    if (err != 0) pid = pid + kd * (err - last_err);
    last_err = err;
    // division truncates toward zero
    vel = bound(pid / Q24, -longint'(cfg_vmax), longint'(cfg_vmax));
    pd  = DRIFT_GAIN * drift;
    fl  = vel * Q24;
    case (cfg_mode)
      MODE_FWD: begin
        l = fl - pd;
        r = fl + pd;
      end
      MODE_BACK: begin
        l = -fl - pd;
        r = -fl + pd;
      end
      MODE_LEFT: begin
        l = -fl - pd;
        r = fl + pd;
      end
      default: begin
        l = fl - pd;
        r = -fl + pd;
      end
    endcase
    c.left  = DRIVE_W'(bound(l / Q24, -DRIVE_CAP, DRIVE_CAP));
    c.right = DRIVE_W'(bound(r / Q24, -DRIVE_CAP, DRIVE_CAP));
    return c;
  endfunction

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_cnt = 0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) cmds_due.push_back(compute_drive_cmd(on_bus));
      if (gap_cnt > 0) begin
        gap_cnt--;
        item_valid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        on_bus     <= tick_queue.pop_front();
        item_valid <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap_cnt = $urandom_range(1, 8);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    drive_cmd_t want;
    if (rst) begin
      result_ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (cmds_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0d",
                   $time, left_drive, right_drive, catapult_drive, status);
          mismatches++;
        end else begin
          want = cmds_due.pop_front();
          report_field("left_drive", want.left, left_drive);
          report_field("right_drive", want.right, right_drive);
          report_field("catapult_drive", want.catapult, catapult_drive);
          report_field("status", want.status, status);
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) stall_cnt = $urandom_range(1, 8);
      end
    end
  end

  // watchdog: no beat and no register write for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("differential_drive_pid_step regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // call right after a rising edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:    cfg_mode    = value[MODE_W-1:0];
      REG_TARGET:  cfg_target  = value[TARGET_W-1:0];
      REG_MAX_VEL: cfg_vmax    = value[VEL_W-1:0];
      default:     cfg_timeout = value[TIME_W-1:0];
    endcase
  endtask

  task automatic set_config(logic [1:0] m, longint tgt, longint vm, longint tmo);
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_TARGET, 32'(tgt));
    write_reg(REG_MAX_VEL, 32'(vm));
    write_reg(REG_TIMEOUT, 32'(tmo));
  endtask

  // wait until every queued beat is accepted and every command has arrived;
  // checked on the falling edge so the driver's updates have settled
  task automatic drain();
    while (tick_queue.size() != 0 || item_valid || cmds_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_tick(logic o, longint l, longint r, longint g, longint p, longint e);
    tick_t t;
    t.op      = o;
    t.lsum    = l[EB-1:0];
    t.rsum    = r[EB-1:0];
    t.gyro    = g[GYRO_W-1:0];
    t.pot     = p[POT_W-1:0];
    t.elapsed = e[TIME_W-1:0];
    tick_queue.push_back(t);
    items_made++;
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++) begin
      add_tick(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK,
               $urandom_range(0, 1048575), $urandom_range(0, 1048575),
               $urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 65535));
    end
  endtask

  // start, ramp the error from the target down past the stop band, then a
  // few ticks after the finish; hold keeps the error inside the integral zone
  task automatic add_move(int ticks, longint tgt, bit turning, bit hold);
    longint remaining, pos, d, el, l, r, g, p;
    add_tick(OP_START, $urandom_range(0, 1048575), $urandom_range(0, 1048575),
             $urandom_range(0, 65535), $urandom_range(0, 4095), 0);
    el = 0;
    for (int k = 0; k < ticks; k++) begin
      if (hold) remaining = $urandom_range(110, 136);
      else remaining = tgt * (ticks - 1 - k) / ticks + longint'($urandom_range(0, 40)) - 20;
      el  = bound(el + $urandom_range(10, 30), 0, 65535);
      p   = $urandom_range(0, 1) ? $urandom_range(900, 1023) : $urandom_range(0, 4095);
      pos = tgt - remaining;
      if (turning) begin
        pos = bound(pos, 0, 32767);
        g   = $urandom_range(0, 1) ? pos : -pos;
        l   = $urandom_range(0, 1048575);
        if ($urandom_range(0, 1)) r = bound(l + longint'($urandom_range(0, 200)) - 100, 0, 1048575);
        else r = $urandom_range(0, 1048575);
      end else begin
        pos = bound(pos, 0, 1048575);
        d   = $urandom_range(0, 3);
        l   = bound(pos + d, 0, 1048575);
        r   = bound(pos - d, 0, 1048575);
        if ($urandom_range(0, 3) != 0) g = longint'($urandom_range(0, 600)) - 300;
        else g = $urandom_range(0, 65535);
      end
      add_tick(OP_TICK, l, r, g, p, el);
    end
    for (int k = $urandom_range(0, 3); k > 0; k--) begin
      add_tick(OP_TICK, $urandom_range(0, 1048575), $urandom_range(0, 1048575),
               $urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 65535));
    end
  endtask

  task automatic random_phase();
    logic [1:0] m;
    longint     tgt, vm, tmo;
    m = 2'($urandom_range(0, 3));
    if (m == MODE_LEFT || m == MODE_RIGHT) begin
      if ($urandom_range(0, 5) == 0) tgt = $urandom_range(0, 1048575);
      else tgt = $urandom_range(0, 3600);
    end else begin
      case ($urandom_range(0, 7))
        0:       tgt = 0;
        1:       tgt = 1048575;
        2:       tgt = $urandom_range(0, 1048575);
        default: tgt = $urandom_range(0, 20000);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       vm = 0;
      1:       vm = 1;
      2:       vm = 200;
      3:       vm = 600;
      4:       vm = 1023;
      default: vm = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 4))
      0:       tmo = 0;
      1:       tmo = $urandom_range(0, 65535);
      2:       tmo = $urandom_range(100, 1500);
      default: tmo = 65535;
    endcase
    set_config(m, tgt, vm, tmo);
    for (int i = $urandom_range(2, 4); i > 0; i--) begin
      add_move($urandom_range(5, 40), tgt, m[1], 1'b0);
    end
    add_noise($urandom_range(0, 8));
    drain();
  endtask

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: target 0 ends the move on the first tick
    idle_pct = 20;
    add_tick(OP_TICK, 0, 0, 0, 0, 0);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    drain();

    set_config(MODE_FWD, 1000, 1023, 65535);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 0, 0, -32768, 4095, 0);
    add_tick(OP_TICK, 863, 863, 32767, 961, 20);    // just outside the zone
    add_tick(OP_TICK, 864, 864, 0, 960, 40);        // zone edge
    add_tick(OP_TICK, 975, 975, 100, 0, 60);
    add_tick(OP_TICK, 975, 976, -100, 2000, 80);    // error exactly at stop band
    add_tick(OP_TICK, 1951, 1951, 0, 0, 100);       // overshoot, reached
    add_tick(OP_TICK, 0, 0, 0, 4095, 120);          // held
    add_tick(OP_START, 1048575, 1048575, 0, 0, 0);
    add_tick(OP_TICK, 1048575, 1048575, 0, 0, 0);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 0, 0, 0, 4095, 65535);        // timeout at equality
    add_tick(OP_TICK, 0, 0, 0, 4095, 0);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 0, 0, 0, 0, 65534);
    drain();

    set_config(MODE_LEFT, 3600, 600, 1000);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 1048575, 0, 0, 1000, 0);      // drive saturates
    add_tick(OP_TICK, 0, 1048575, -3575, 1000, 999);
    add_tick(OP_TICK, 0, 0, 3576, 1000, 1000);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 5, 7, 100, 0, 1000);
    add_tick(OP_START, 0, 0, 0, 0, 0);
    add_tick(OP_TICK, 5, 7, -32768, 0, 0);
    drain();

    phase = 0;
    while (items_made < 1450) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 40;
      endcase
      if (phase == 3) begin
        // long stay in the zone drives the integrator into its clamp
        set_config(MODE_FWD, 5000, 600, 65535);
        add_move(420, 5000, 1'b0, 1'b1);
        drain();
      end else begin
        random_phase();
      end
      phase++;
    end

    idle_pct = 0;
    while (items_made < 1600) random_phase();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("differential_drive_pid_step regression: pass");
    end else begin
      $display("differential_drive_pid_step regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ddps_pkg.sv
hw/rtl/ddps_track.sv
hw/rtl/ddps_drive.sv
hw/rtl/differential_drive_pid_step.sv
sim/testbench.sv
